// ----- src/spectrum_band_level_decay_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the spectrum band level decay unit
// These are clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_BAND_LEVEL_DECAY_UNIT_ASSERT_SVH
`define SPECTRUM_BAND_LEVEL_DECAY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SBLD_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbld same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define SBLD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbld next-cycle check failed");
`else
`define SBLD_ASSERT_SAME(name, ante, cons)
`define SBLD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- src/sbld_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbld_pkg
// Shared constants, weight table and control types of the band level unit.
// ----------------------------------------------------------------------------
package sbld_pkg;

    localparam int MAX_BANDS         = 32;
    localparam int MAX_BINS_PER_BAND = 64;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_DECAY_RATE    = 2'd0;
    localparam logic [1:0] REG_BINS_PER_BAND = 2'd1;
    localparam logic [1:0] REG_BANDS_IN_USE  = 2'd2;

    localparam logic [15:0] DECAY_RATE_RESET    = 16'd3277;
    localparam logic [6:0]  BINS_PER_BAND_RESET = 7'd8;
    localparam logic [5:0]  BANDS_IN_USE_RESET  = 6'd30;

    localparam logic [6:0] BINS_LIMIT  = 7'(MAX_BINS_PER_BAND);
    localparam logic [5:0] BANDS_LIMIT = 6'(MAX_BANDS);

    // Level thresholds in Q.24.
    localparam logic [41:0] TH_X50_LO = 42'd83886;
    localparam logic [41:0] TH_X50_HI = 42'd150995;
    localparam logic [41:0] TH_X10_LO = 42'd167772;
    localparam logic [41:0] TH_X10_HI = 42'd1677722;
    localparam logic [41:0] TH_PI_HI  = 42'd8388608;
    localparam logic [41:0] ONE_Q24   = 42'd16777216;

    localparam logic [17:0] PI_Q16 = 18'd205887;

    // ln(n) for n = 2..33 in Q2.16.
    localparam logic [17:0] LN_ROM [32] = '{
        18'd45426,  18'd71999,  18'd90852,  18'd105476,
        18'd117425, 18'd127527, 18'd136278, 18'd143997,
        18'd150902, 18'd157148, 18'd162851, 18'd168097,
        18'd172953, 18'd177475, 18'd181704, 18'd185677,
        18'd189423, 18'd192967, 18'd196328, 18'd199526,
        18'd202575, 18'd205488, 18'd208277, 18'd210952,
        18'd213523, 18'd215996, 18'd218379, 18'd220679,
        18'd222901, 18'd225050, 18'd227130, 18'd229147
    };

    typedef struct packed {
        logic       sum_add;
        logic       sum_clear;
        logic       capture;
        logic [4:0] band;
        logic       last_band;
        logic       mul_lo;
        logic       mul_hi;
        logic       boost;
        logic       emit;
    } sbld_cmd_t;

    typedef struct packed {
        logic out_free;
    } sbld_status_t;

endpackage

// ----- src/sbld_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbld_ctrl
// Sequencer for the band level unit: bin and band counters, band size
// registers and the state machine that steps the band-end arithmetic.
// ----------------------------------------------------------------------------
`include "spectrum_band_level_decay_unit_assert.svh"

module sbld_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  frame_end,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  sbld_pkg::sbld_status_t status,
    output sbld_pkg::sbld_cmd_t   cmd
);
    import sbld_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_BOOST  = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [5:0] bin_cnt_reg;
    logic [5:0] bin_cnt_next;
    logic [5:0] band_cnt_reg;
    logic [5:0] band_cnt_next;
    logic [6:0] bins_reg;
    logic [5:0] bands_reg;

    logic [6:0] eff_bins;
    logic [5:0] eff_bands;
    logic       accept;
    logic       in_range;
    logic       band_done;

    always_comb
    begin
        eff_bins = bins_reg;
        if (bins_reg == 7'd0)
        begin
            eff_bins = 7'd1;
        end
        else if (bins_reg > BINS_LIMIT)
        begin
            eff_bins = BINS_LIMIT;
        end
        eff_bands = bands_reg;
        if (bands_reg == 6'd0)
        begin
            eff_bands = 6'd1;
        end
        else if (bands_reg > BANDS_LIMIT)
        begin
            eff_bands = BANDS_LIMIT;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign in_range  = (band_cnt_reg < eff_bands);
    assign band_done = in_range && (({1'b0, bin_cnt_reg} + 7'd1) >= eff_bins);

    always_comb
    begin
        bin_cnt_next  = bin_cnt_reg;
        band_cnt_next = band_cnt_reg;
        if (accept)
        begin
            if (band_done)
            begin
                bin_cnt_next  = 6'd0;
                band_cnt_next = band_cnt_reg + 6'd1;
            end
            else if (in_range)
            begin
                bin_cnt_next = bin_cnt_reg + 6'd1;
            end
            if (frame_end)
            begin
                bin_cnt_next  = 6'd0;
                band_cnt_next = 6'd0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && band_done)
                begin
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_BOOST;
            ST_BOOST:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.sum_add   = accept && in_range;
        cmd.sum_clear = accept && (band_done || frame_end);
        cmd.capture   = accept && band_done;
        cmd.band      = band_cnt_reg[4:0];
        cmd.last_band = ((band_cnt_reg + 6'd1) == eff_bands);
        cmd.mul_lo    = (state_reg == ST_MUL_LO);
        cmd.mul_hi    = (state_reg == ST_MUL_HI);
        cmd.boost     = (state_reg == ST_BOOST);
        cmd.emit      = (state_reg == ST_EMIT) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bin_cnt_reg  <= 6'd0;
            band_cnt_reg <= 6'd0;
            bins_reg     <= BINS_PER_BAND_RESET;
            bands_reg    <= BANDS_IN_USE_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            bin_cnt_reg  <= bin_cnt_next;
            band_cnt_reg <= band_cnt_next;
            if (cfg_we && (cfg_index == REG_BINS_PER_BAND))
            begin
                bins_reg <= cfg_data[6:0];
            end
            if (cfg_we && (cfg_index == REG_BANDS_IN_USE))
            begin
                bands_reg <= cfg_data[5:0];
            end
        end
    end

    // Only a bin that closes a band may start the arithmetic sequence.
    `SBLD_ASSERT_NEXT(a_idle_holds, (state_reg == ST_IDLE) && !(accept && band_done), state_reg == ST_IDLE)
    // A result that cannot be handed over keeps the sequencer waiting.
    `SBLD_ASSERT_NEXT(a_emit_waits, (state_reg == ST_EMIT) && !status.out_free, state_reg == ST_EMIT)
    // The band counter never runs past the largest band count.
    `SBLD_ASSERT_SAME(a_band_bound, 1'b1, band_cnt_reg <= BANDS_LIMIT)

endmodule

// ----- src/sbld_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbld_datapath
// Band accumulator, weight multiply, piecewise boost, decay against the held
// levels and the output register.
// ----------------------------------------------------------------------------
`include "spectrum_band_level_decay_unit_assert.svh"

module sbld_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sbld_pkg::sbld_cmd_t    cmd,
    output sbld_pkg::sbld_status_t status,
    input  logic [31:0]            bin_magnitude,
    input  logic [15:0]            frame_ratio,
    input  logic                   cfg_we,
    input  logic [1:0]             cfg_index,
    input  logic [15:0]            cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [24:0]            band_level,
    output logic [4:0]             band_number,
    output logic                   final_band
);
    import sbld_pkg::*;

    logic [15:0] decay_rate_reg;
    logic [39:0] sum_reg;
    logic [39:0] sum_next;
    logic [39:0] shape_sum_reg;
    logic [4:0]  band_reg;
    logic        last_reg;
    logic [27:0] decay_reg;
    logic [49:0] prod_reg;
    logic [41:0] w_reg;
    logic [24:0] wclamp_reg;
    logic [24:0] held_reg [MAX_BANDS];
    logic        out_valid_reg;
    logic [24:0] level_reg;
    logic [4:0]  number_reg;
    logic        final_reg;

    logic [31:0] decay_prod;
    logic [17:0] weight;
    logic [25:0] hi_prod;
    logic [57:0] full_prod;
    logic [40:0] pi_prod;
    logic [40:0] pi_round;
    logic [41:0] boosted;
    logic [41:0] clamped;
    logic [27:0] held_ext;
    logic [27:0] held_less;
    logic [24:0] level_next;

    assign sum_next   = sum_reg + {8'd0, bin_magnitude};
    assign decay_prod = (decay_rate_reg * frame_ratio) + 32'd8;
    assign weight     = LN_ROM[band_reg];
    assign hi_prod    = shape_sum_reg[39:32] * weight;
    assign full_prod  = {hi_prod, 32'd0} + {8'd0, prod_reg} + 58'd32768;
    assign pi_prod    = w_reg[22:0] * PI_Q16;
    assign pi_round   = pi_prod + 41'd32768;

    always_comb
    begin
        if ((w_reg > TH_X50_LO) && (w_reg < TH_X50_HI))
        begin
            boosted = 42'({w_reg[17:0], 5'd0}) + 42'({w_reg[17:0], 4'd0})
                    + 42'({w_reg[17:0], 1'b0});
        end
        else if ((w_reg > TH_X10_LO) && (w_reg < TH_X10_HI))
        begin
            boosted = 42'({w_reg[20:0], 3'd0}) + 42'({w_reg[20:0], 1'b0});
        end
        else if ((w_reg > TH_X10_HI) && (w_reg < TH_PI_HI))
        begin
            boosted = 42'(pi_round[40:16]);
        end
        else
        begin
            boosted = w_reg;
        end
        clamped = (boosted > ONE_Q24) ? ONE_Q24 : boosted;
    end

    // The held level falls by the decay unless the new level is higher.
    always_comb
    begin
        held_ext   = {3'd0, held_reg[band_reg]};
        held_less  = held_ext - decay_reg;
        level_next = wclamp_reg;
        if ((held_ext > decay_reg) && ({3'd0, wclamp_reg} < held_less))
        begin
            level_next = held_less[24:0];
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            shape_sum_reg <= sum_next;
            band_reg      <= cmd.band;
            last_reg      <= cmd.last_band;
            decay_reg     <= decay_prod[31:4];
        end
        if (cmd.mul_lo)
        begin
            prod_reg <= shape_sum_reg[31:0] * weight;
        end
        if (cmd.mul_hi)
        begin
            w_reg <= full_prod[57:16];
        end
        if (cmd.boost)
        begin
            wclamp_reg <= clamped[24:0];
        end
        if (cmd.emit)
        begin
            level_reg  <= level_next;
            number_reg <= band_reg;
            final_reg  <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_rate_reg <= DECAY_RATE_RESET;
            sum_reg        <= 40'd0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_BANDS; i++)
            begin
                held_reg[i] <= 25'd0;
            end
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_DECAY_RATE))
            begin
                decay_rate_reg <= cfg_data;
            end
            if (cmd.sum_clear)
            begin
                sum_reg <= 40'd0;
            end
            else if (cmd.sum_add)
            begin
                sum_reg <= sum_next;
            end
            if (cmd.emit)
            begin
                held_reg[band_reg] <= level_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign band_level  = level_reg;
    assign band_number = number_reg;
    assign final_band  = final_reg;

    // The clamped level never exceeds full scale.
    `SBLD_ASSERT_NEXT(a_clamp_bound, cmd.boost, {17'd0, wclamp_reg} <= ONE_Q24)
    // A handed-over level always presents a word on the next cycle.
    `SBLD_ASSERT_NEXT(a_emit_valid, cmd.emit, out_valid_reg)

endmodule

// ----- src/spectrum_band_level_decay_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_band_level_decay_unit
// Sums FFT bins into bands and produces a decaying display level per band.
// ----------------------------------------------------------------------------
// Usage:
// Bins enter on the in channel (in_valid/in_ready), one word each, with
// bin_magnitude, frame_ratio and frame_end. A bin that does not close a band
// leaves in_ready high for the next bin. A bin that closes a band holds
// in_ready low while the arithmetic runs: the weight multiply is split into
// a low and a high partial product, then boost and clamp, then the decay
// compare loads the output register, and the band level appears on the out
// channel (out_valid/out_ready). The output register lets the next bins
// enter while a level waits; if the receiver stalls and another band closes,
// in_ready stays low until the waiting word is taken.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
// Reset clears the counters, the band sum and all 32 held levels, and loads
// the default decay rate, bins per band and band count.
// ----------------------------------------------------------------------------
module spectrum_band_level_decay_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] bin_magnitude,
    input  logic [15:0] frame_ratio,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [24:0] band_level,
    output logic [4:0]  band_number,
    output logic        final_band,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import sbld_pkg::*;

    sbld_cmd_t    cmd;
    sbld_status_t status;

    sbld_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .frame_end (frame_end),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .cmd       (cmd)
    );

    sbld_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .bin_magnitude (bin_magnitude),
        .frame_ratio   (frame_ratio),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .band_level    (band_level),
        .band_number   (band_number),
        .final_band    (final_band)
    );

endmodule
